// File: rtl/mcpp_pkg.sv
// ----------------------------------------------------------------------------
// mcpp_pkg
// Shared types and codes of the MQTT control packet header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpp_pkg;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	// MQTT control packet types
	localparam logic [3:0] PT_CONNECT    = 4'd1;
	localparam logic [3:0] PT_CONNACK    = 4'd2;
	localparam logic [3:0] PT_PUBLISH    = 4'd3;
	localparam logic [3:0] PT_SUBSCRIBE  = 4'd8;
	localparam logic [3:0] PT_SUBACK     = 4'd9;
	localparam logic [3:0] PT_PINGREQ    = 4'd12;
	localparam logic [3:0] PT_PINGRESP   = 4'd13;
	localparam logic [3:0] PT_DISCONNECT = 4'd14;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] buffer_length;
		logic        first_byte;
	} byte_item_t;

	typedef struct packed {
		logic [3:0]  packet_type;
		logic [1:0]  status;
		logic        dup_flag;
		logic [1:0]  header_qos;
		logic [7:0]  remaining_length;
		logic [15:0] id_or_keepalive;
		logic [7:0]  small_value;
		logic [7:0]  connect_flag_bits;
		logic [15:0] name_offset;
		logic [15:0] name_length;
		logic [15:0] body_offset;
		logic [15:0] body_length;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/mcpp_if.sv
// ----------------------------------------------------------------------------
// mcpp_if
// Valid/ready channels: receive-buffer bytes in, parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcpp_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] buffer_length;
	logic        first_byte;

	modport source (output valid, data_byte, buffer_length, first_byte, input ready);
	modport sink   (input valid, data_byte, buffer_length, first_byte, output ready);
endinterface

interface mcpp_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  packet_type;
	logic [1:0]  status;
	logic        dup_flag;
	logic [1:0]  header_qos;
	logic [7:0]  remaining_length;
	logic [15:0] id_or_keepalive;
	logic [7:0]  small_value;
	logic [7:0]  connect_flag_bits;
	logic [15:0] name_offset;
	logic [15:0] name_length;
	logic [15:0] body_offset;
	logic [15:0] body_length;

	modport source (output valid, packet_type, status, dup_flag, header_qos,
		remaining_length, id_or_keepalive, small_value, connect_flag_bits,
		name_offset, name_length, body_offset, body_length, input ready);
	modport sink   (input valid, packet_type, status, dup_flag, header_qos,
		remaining_length, id_or_keepalive, small_value, connect_flag_bits,
		name_offset, name_length, body_offset, body_length, output ready);
endinterface

`default_nettype wire

// File: rtl/mqtt_control_packet_parser.sv
// ----------------------------------------------------------------------------
// mqtt_control_packet_parser
// Parses a receive buffer, one byte per transfer, into MQTT control packet
// header results.
//
//   channel     dir   carries
//   byte_ch     in    data_byte, buffer_length, first_byte
//   result_ch   out   packet type, status, header flags, captured fields
//
// One byte per cycle sustained while result_ch takes results; a byte's result
// reaches result_ch through the input register, loaded by the transfer, and
// the result register, loaded by one parse step. The parse state updates in a
// single step, so bytes flow back to back. A stalled result_ch holds the result
// register and backs up byte_ch once the input register is full. Reset is
// asynchronous and clears the valid flags and parse state, not data registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_control_packet_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mcpp_byte_if.sink   byte_ch,
	mcpp_result_if.source result_ch
);

	logic                  valid_s1;
	mcpp_pkg::byte_item_t  item_s1;
	logic                  space;
	logic                  advance;
	logic                  res_valid;
	mcpp_pkg::result_t     res;

	assign advance = valid_s1 && space;

	mcpp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mcpp_parse_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.item       (item_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	mcpp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.space     (space),
		.result_ch (result_ch)
	);

endmodule

`default_nettype wire

// File: rtl/mcpp_in_reg.sv
// ----------------------------------------------------------------------------
// mcpp_in_reg
// Input register stage: holds one byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpp_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mcpp_byte_if.sink               byte_ch,
	input  wire logic               take,
	output logic                    valid_s1,
	output mcpp_pkg::byte_item_t    item_s1
);

	assign byte_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			item_s1.data_byte     <= byte_ch.data_byte;
			item_s1.buffer_length <= byte_ch.buffer_length;
			item_s1.first_byte    <= byte_ch.first_byte;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mcpp_parse_core.sv
// ----------------------------------------------------------------------------
// mcpp_parse_core
// Parse state and the per-byte step; gives a result on the consumed byte that completes, rejects or truncates a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpp_parse_core #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire mcpp_pkg::byte_item_t item,
	output logic                    res_valid,
	output mcpp_pkg::result_t       res
);

	localparam int CW = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	localparam logic [4:0] PH_HDR  = 5'd0;
	localparam logic [4:0] PH_LEN  = 5'd1;
	localparam logic [4:0] C_NLH   = 5'd2;
	localparam logic [4:0] C_NLL   = 5'd3;
	localparam logic [4:0] C_NSKIP = 5'd4;
	localparam logic [4:0] C_VER   = 5'd5;
	localparam logic [4:0] C_FLG   = 5'd6;
	localparam logic [4:0] C_KAH   = 5'd7;
	localparam logic [4:0] C_KAL   = 5'd8;
	localparam logic [4:0] C_CIH   = 5'd9;
	localparam logic [4:0] C_CIL   = 5'd10;
	localparam logic [4:0] C_CSKIP = 5'd11;
	localparam logic [4:0] CA_RES  = 5'd12;
	localparam logic [4:0] CA_CODE = 5'd13;
	localparam logic [4:0] S_IDH   = 5'd14;
	localparam logic [4:0] S_IDL   = 5'd15;
	localparam logic [4:0] S_TLH   = 5'd16;
	localparam logic [4:0] S_TLL   = 5'd17;
	localparam logic [4:0] S_TSKIP = 5'd18;
	localparam logic [4:0] S_QOS   = 5'd19;
	localparam logic [4:0] SA_IDH  = 5'd20;
	localparam logic [4:0] SA_IDL  = 5'd21;
	localparam logic [4:0] SA_QOS  = 5'd22;
	localparam logic [4:0] P_TLH   = 5'd23;
	localparam logic [4:0] P_TLL   = 5'd24;
	localparam logic [4:0] P_TSKIP = 5'd25;
	localparam logic [4:0] P_PAY   = 5'd26;

	logic [4:0]             phase_q, phase_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [15:0]            skip_q, skip_n;
	logic                   halt_q, halt_n;
	logic [7:0]             hdr_q, hdr_n;
	logic [7:0]             lenb_q, lenb_n;
	logic [15:0]            word_q, word_n;
	logic [7:0]             bcap_q, bcap_n;
	logic [7:0]             flags_q, flags_n;
	logic [15:0]            nstart_q, nstart_n;
	logic [15:0]            ncount_q, ncount_n;
	logic [7:0]             lenhi_q, lenhi_n;
	logic [15:0]            bstart_q, bstart_n;
	logic [15:0]            bcount_q, bcount_n;

	logic [OFFSET_BITS-1:0] off_e;
	logic [4:0]             phase_e;
	logic                   halt_e;
	logic [CW-1:0]          o_w, blen_w, op1_w, op1_mx;
	logic [OFFSET_BITS-1:0] op1_m;
	logic [15:0]            pos16, left16, len16, skip_dec;
	logic                   active, last, len_bad;
	logic [3:0]             ptype;
	logic                   emit;
	logic [1:0]             st;

	always_comb begin
		off_e   = item.first_byte ? '0 : off_q;
		phase_e = item.first_byte ? PH_HDR : phase_q;
		halt_e  = item.first_byte ? 1'b0 : halt_q;

		o_w    = CW'(off_e);
		blen_w = CW'(item.buffer_length);
		op1_w  = o_w + CW'(1);
		op1_m  = op1_w[OFFSET_BITS-1:0];
		op1_mx = CW'(op1_m);
		pos16  = op1_mx[15:0];
		// o < blen here, so this difference fits and is never negative
		left16 = item.buffer_length - op1_w[15:0];
		len16  = {lenhi_q, item.data_byte};
		len_bad  = len16 > left16;
		skip_dec = skip_q - 16'd1;
		active = !halt_e && (o_w < blen_w);
		last   = (op1_w == blen_w);
		ptype  = hdr_q[7:4];

		phase_n  = phase_e;
		off_n    = off_e;
		halt_n   = halt_e;
		skip_n   = skip_q;
		hdr_n    = hdr_q;
		lenb_n   = lenb_q;
		word_n   = word_q;
		bcap_n   = bcap_q;
		flags_n  = flags_q;
		nstart_n = nstart_q;
		ncount_n = ncount_q;
		lenhi_n  = lenhi_q;
		bstart_n = bstart_q;
		bcount_n = bcount_q;
		emit     = 1'b0;
		st       = mcpp_pkg::ST_OK;

		if (active) begin
			case (phase_e)
				PH_HDR: begin
					hdr_n    = item.data_byte;
					lenb_n   = '0;
					word_n   = '0;
					bcap_n   = '0;
					flags_n  = '0;
					nstart_n = '0;
					ncount_n = '0;
					lenhi_n  = '0;
					bstart_n = '0;
					bcount_n = '0;
					phase_n  = PH_LEN;
				end
				PH_LEN: begin
					lenb_n = item.data_byte;
					case (ptype)
						mcpp_pkg::PT_CONNECT:   phase_n = C_NLH;
						mcpp_pkg::PT_CONNACK:   phase_n = CA_RES;
						mcpp_pkg::PT_PUBLISH:   phase_n = P_TLH;
						mcpp_pkg::PT_SUBSCRIBE: phase_n = S_IDH;
						mcpp_pkg::PT_SUBACK:    phase_n = SA_IDH;
						mcpp_pkg::PT_PINGREQ, mcpp_pkg::PT_PINGRESP,
						mcpp_pkg::PT_DISCONNECT: begin
							emit    = 1'b1;
							phase_n = PH_HDR;
							if (item.data_byte != 8'd0 || !last) begin
								st     = mcpp_pkg::ST_MALFORMED;
								halt_n = 1'b1;
							end
						end
						default: begin
							emit    = 1'b1;
							phase_n = PH_HDR;
						end
					endcase
				end
				C_NLH, C_CIH, S_TLH, P_TLH: begin
					lenhi_n = item.data_byte;
					phase_n = phase_e + 5'd1;
				end
				C_NLL, S_TLL, P_TLL: begin
					if (len_bad) begin
						emit    = 1'b1;
						st      = mcpp_pkg::ST_MALFORMED;
						halt_n  = 1'b1;
						phase_n = PH_HDR;
					end else begin
						nstart_n = pos16;
						ncount_n = len16;
						if (len16 != 16'd0) begin
							skip_n  = len16;
							phase_n = phase_e + 5'd1;
						end else if (phase_e == P_TLL) begin
							// empty topic: payload is the rest of the buffer
							bstart_n = pos16;
							bcount_n = left16;
							if (left16 == 16'd0) begin
								emit    = 1'b1;
								phase_n = PH_HDR;
							end else begin
								phase_n = P_PAY;
							end
						end else begin
							phase_n = phase_e + 5'd2;
						end
					end
				end
				C_NSKIP, S_TSKIP, P_TSKIP, C_CSKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 16'd0) begin
						if (phase_e == P_TSKIP) begin
							bstart_n = pos16;
							bcount_n = left16;
							if (left16 == 16'd0) begin
								emit    = 1'b1;
								phase_n = PH_HDR;
							end else begin
								phase_n = P_PAY;
							end
						end else if (phase_e == C_CSKIP) begin
							emit    = 1'b1;
							phase_n = PH_HDR;
						end else begin
							phase_n = phase_e + 5'd1;
						end
					end
				end
				C_VER: begin
					bcap_n  = item.data_byte;
					phase_n = C_FLG;
				end
				C_FLG: begin
					flags_n = item.data_byte;
					phase_n = C_KAH;
				end
				C_KAH, S_IDH, SA_IDH: begin
					word_n  = {item.data_byte, 8'd0};
					phase_n = phase_e + 5'd1;
				end
				C_KAL, S_IDL, SA_IDL: begin
					word_n  = {word_q[15:8], item.data_byte};
					phase_n = phase_e + 5'd1;
				end
				C_CIL: begin
					if (len_bad) begin
						emit    = 1'b1;
						st      = mcpp_pkg::ST_MALFORMED;
						halt_n  = 1'b1;
						phase_n = PH_HDR;
					end else begin
						bstart_n = pos16;
						bcount_n = len16;
						if (len16 != 16'd0) begin
							skip_n  = len16;
							phase_n = C_CSKIP;
						end else begin
							emit    = 1'b1;
							phase_n = PH_HDR;
						end
					end
				end
				CA_RES: phase_n = CA_CODE;
				CA_CODE, S_QOS, SA_QOS: begin
					bcap_n  = item.data_byte;
					emit    = 1'b1;
					phase_n = PH_HDR;
				end
				P_PAY: begin
					if (last) begin
						emit    = 1'b1;
						phase_n = PH_HDR;
					end
				end
				default: phase_n = PH_HDR;
			endcase

			off_n = (op1_w > CW'(OFF_MAX)) ? OFF_MAX : op1_m;

			// buffer ran out inside a packet
			if (!emit && last && phase_n != PH_HDR && !halt_n) begin
				emit   = 1'b1;
				st     = mcpp_pkg::ST_TRUNCATED;
				halt_n = 1'b1;
			end
		end
	end

	assign res_valid = item_valid && emit;

	always_comb begin
		res.packet_type       = hdr_n[7:4];
		res.status            = st;
		res.dup_flag          = hdr_n[3];
		res.header_qos        = hdr_n[2:1];
		res.remaining_length  = lenb_n;
		res.id_or_keepalive   = word_n;
		res.small_value       = bcap_n;
		res.connect_flag_bits = flags_n;
		res.name_offset       = nstart_n;
		res.name_length       = ncount_n;
		res.body_offset       = bstart_n;
		res.body_length       = bcount_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			off_q    <= '0;
			skip_q   <= '0;
			halt_q   <= 1'b0;
			hdr_q    <= '0;
			lenb_q   <= '0;
			word_q   <= '0;
			bcap_q   <= '0;
			flags_q  <= '0;
			nstart_q <= '0;
			ncount_q <= '0;
			lenhi_q  <= '0;
			bstart_q <= '0;
			bcount_q <= '0;
		end else if (item_valid) begin
			phase_q  <= phase_n;
			off_q    <= off_n;
			skip_q   <= skip_n;
			halt_q   <= halt_n;
			hdr_q    <= hdr_n;
			lenb_q   <= lenb_n;
			word_q   <= word_n;
			bcap_q   <= bcap_n;
			flags_q  <= flags_n;
			nstart_q <= nstart_n;
			ncount_q <= ncount_n;
			lenhi_q  <= lenhi_n;
			bstart_q <= bstart_n;
			bcount_q <= bcount_n;
		end
	end

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == C_NSKIP || phase_q == S_TSKIP || phase_q == P_TSKIP ||
		 phase_q == C_CSKIP) |-> skip_q != 16'd0)
		else $error("skip phase with zero count");

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_PAY |-> bcount_q != 16'd0)
		else $error("payload phase with empty payload");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.status == mcpp_pkg::ST_OK ||
			res.status == mcpp_pkg::ST_MALFORMED ||
			res.status == mcpp_pkg::ST_TRUNCATED))
		else $error("bad status code");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && halt_q && !item.first_byte) |-> !res_valid)
		else $error("result while halted");

endmodule

`default_nettype wire

// File: rtl/mcpp_out_reg.sv
// ----------------------------------------------------------------------------
// mcpp_out_reg
// Result register: holds one result until the sink takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpp_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire mcpp_pkg::result_t  res,
	output logic                    space,
	mcpp_result_if.source           result_ch
);

	logic               valid_q;
	mcpp_pkg::result_t  res_q;

	assign space = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res;
		end
	end

	assign result_ch.valid             = valid_q;
	assign result_ch.packet_type       = res_q.packet_type;
	assign result_ch.status            = res_q.status;
	assign result_ch.dup_flag          = res_q.dup_flag;
	assign result_ch.header_qos        = res_q.header_qos;
	assign result_ch.remaining_length  = res_q.remaining_length;
	assign result_ch.id_or_keepalive   = res_q.id_or_keepalive;
	assign result_ch.small_value       = res_q.small_value;
	assign result_ch.connect_flag_bits = res_q.connect_flag_bits;
	assign result_ch.name_offset       = res_q.name_offset;
	assign result_ch.name_length       = res_q.name_length;
	assign result_ch.body_offset       = res_q.body_offset;
	assign result_ch.body_length       = res_q.body_length;

endmodule

`default_nettype wire
